@@ rtl/core/servo_angle_to_pulse_mapper_defines.svh @@
// Assertion macros shared by the servo pulse mapper RTL.
`ifndef SERVO_ANGLE_TO_PULSE_MAPPER_DEFINES_SVH
`define SERVO_ANGLE_TO_PULSE_MAPPER_DEFINES_SVH

`ifndef SYNTHESIS
// Check a same-cycle implication on the rising clock edge, quiet during reset.
`define SAPM_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
// Check a next-cycle implication on the rising clock edge, quiet during reset.
`define SAPM_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define SAPM_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)
`define SAPM_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

@@ rtl/core/sapm_pkg.sv @@
// Shared types, widths and register codes of the servo pulse mapper.
package sapm_pkg;

  localparam int unsigned ANGLE_W    = 16;
  localparam int unsigned PULSE_W    = 16;
  localparam int unsigned EXT_W      = ANGLE_W + 1;
  localparam int unsigned DIFF_W     = ANGLE_W + 2;
  localparam int unsigned DP_W       = PULSE_W + 1;
  localparam int unsigned PROD_W     = DIFF_W + DP_W;
  localparam int unsigned NUM_W      = 32;
  localparam int unsigned DEN_W      = 16;
  localparam int unsigned DIV_STAGES = NUM_W;
  localparam int unsigned SUM_W      = NUM_W + 2;
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Register indexes of the configuration port
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_PULSE_LOW    = 3'd0,
    REG_PULSE_CENTER = 3'd1,
    REG_PULSE_HIGH   = 3'd2,
    REG_ANGLE_LOWER  = 3'd3,
    REG_ANGLE_UPPER  = 3'd4,
    REG_INVERT_ANGLE = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic        [PULSE_W-1:0] pulse_low;
    logic        [PULSE_W-1:0] pulse_center;
    logic        [PULSE_W-1:0] pulse_high;
    logic signed [ANGLE_W-1:0] angle_lower;
    logic signed [ANGLE_W-1:0] angle_upper;
    logic                      invert_angle;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    pulse_low:    16'd1100,
    pulse_center: 16'd1130,
    pulse_high:   16'd1230,
    angle_lower:  16'hFFCE,
    angle_upper:  16'd100,
    invert_angle: 1'b0
  };

  // Segment data that rides along with one item down the pipe
  typedef struct packed {
    logic [PULSE_W-1:0] base;
    logic [PULSE_W-1:0] clamp_lo;
    logic [PULSE_W-1:0] clamp_hi;
    logic [PULSE_W-1:0] center;
    logic               zero_den;
  } seg_t;

endpackage

@@ rtl/core/sapm_if.sv @@
// Handshake channel interfaces of the servo pulse mapper.
interface sapm_angle_if;
  import sapm_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [ANGLE_W-1:0] angle;
  modport source (output valid, output angle, input ready);
  modport sink (input valid, input angle, output ready);
endinterface

interface sapm_pulse_if;
  import sapm_pkg::*;
  logic               valid;
  logic               ready;
  logic [PULSE_W-1:0] pulse_width;
  modport source (output valid, output pulse_width, input ready);
  modport sink (input valid, input pulse_width, output ready);
endinterface

interface sapm_cfg_if;
  import sapm_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_ADDR_W-1:0] addr;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output addr, output data, input ready);
  modport sink (input valid, input addr, input data, output ready);
endinterface

@@ rtl/core/sapm_cfg_regs.sv @@
// Configuration register file of the servo pulse mapper.
module sapm_cfg_regs (
  input  logic            clk_i,
  input  logic            rst_ni,
  sapm_cfg_if.sink        cfg_i,
  output sapm_pkg::cfg_t  cfg_o
);
  import sapm_pkg::*;

  cfg_t cfg_q;

  // Take every write beat at once
  assign cfg_i.ready = 1'b1;

  // Update the addressed register, drop writes beyond the list
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_reg_e'(cfg_i.addr))
        REG_PULSE_LOW:    cfg_q.pulse_low    <= cfg_i.data;
        REG_PULSE_CENTER: cfg_q.pulse_center <= cfg_i.data;
        REG_PULSE_HIGH:   cfg_q.pulse_high   <= cfg_i.data;
        REG_ANGLE_LOWER:  cfg_q.angle_lower  <= $signed(cfg_i.data);
        REG_ANGLE_UPPER:  cfg_q.angle_upper  <= $signed(cfg_i.data);
        REG_INVERT_ANGLE: cfg_q.invert_angle <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ rtl/core/sapm_front.sv @@
// Front stages: clamp and segment select, multiply, sign and magnitude split.
module sapm_front (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 en_i,
  input  logic                                 valid_i,
  input  logic signed [sapm_pkg::ANGLE_W-1:0]  angle_i,
  input  sapm_pkg::cfg_t                       cfg_i,
  output logic                                 valid_o,
  output logic        [sapm_pkg::NUM_W-1:0]    num_o,
  output logic        [sapm_pkg::DEN_W-1:0]    den_o,
  output logic                                 q_neg_o,
  output sapm_pkg::seg_t                       seg_o
);
  import sapm_pkg::*;

  // Stage 1 signals
  logic signed [EXT_W-1:0]  ang_ext;
  logic signed [EXT_W-1:0]  lo_ext;
  logic signed [EXT_W-1:0]  up_ext;
  logic signed [EXT_W-1:0]  clamped;
  logic signed [EXT_W-1:0]  x_ang;
  logic                     seg_neg;
  logic signed [DIFF_W-1:0] diff_d;
  logic signed [DP_W-1:0]   dp_d;
  logic signed [EXT_W-1:0]  den_d;
  seg_t                     seg_d;

  logic                     valid1_q;
  logic signed [DIFF_W-1:0] diff_q;
  logic signed [DP_W-1:0]   dp_q;
  logic signed [EXT_W-1:0]  den1_q;
  seg_t                     seg1_q;

  // Stage 2 signals
  logic signed [PROD_W-1:0] prod_d;
  logic signed [EXT_W-1:0]  den_abs;
  logic                     valid2_q;
  logic signed [PROD_W-1:0] prod_q;
  logic        [DEN_W-1:0]  den2_q;
  logic                     den_neg2_q;
  seg_t                     seg2_q;

  // Stage 3 signals
  logic signed [PROD_W-1:0] prod_abs;
  logic                     valid3_q;
  logic        [NUM_W-1:0]  num3_q;
  logic        [DEN_W-1:0]  den3_q;
  logic                     q_neg3_q;
  seg_t                     seg3_q;

  // Clamp low bound first, invert, pick the segment
  always_comb begin
    ang_ext = {angle_i[ANGLE_W-1], angle_i};
    lo_ext  = {cfg_i.angle_lower[ANGLE_W-1], cfg_i.angle_lower};
    up_ext  = {cfg_i.angle_upper[ANGLE_W-1], cfg_i.angle_upper};
    if (ang_ext < lo_ext) begin
      clamped = lo_ext;
    end else if (ang_ext > up_ext) begin
      clamped = up_ext;
    end else begin
      clamped = ang_ext;
    end
    x_ang   = cfg_i.invert_angle ? -clamped : clamped;
    seg_neg = x_ang[EXT_W-1];
    if (seg_neg) begin
      diff_d         = {x_ang[EXT_W-1], x_ang} - {lo_ext[EXT_W-1], lo_ext};
      dp_d           = $signed({1'b0, cfg_i.pulse_center}) - $signed({1'b0, cfg_i.pulse_low});
      den_d          = -lo_ext;
      seg_d.base     = cfg_i.pulse_low;
      seg_d.clamp_lo = cfg_i.pulse_low;
      seg_d.clamp_hi = cfg_i.pulse_center;
    end else begin
      diff_d         = {x_ang[EXT_W-1], x_ang};
      dp_d           = $signed({1'b0, cfg_i.pulse_high}) - $signed({1'b0, cfg_i.pulse_center});
      den_d          = up_ext;
      seg_d.base     = cfg_i.pulse_center;
      seg_d.clamp_lo = cfg_i.pulse_center;
      seg_d.clamp_hi = cfg_i.pulse_high;
    end
    seg_d.center   = cfg_i.pulse_center;
    seg_d.zero_den = (den_d == '0);
  end

  // Multiply, and take the divisor magnitude
  assign prod_d  = $signed({{(PROD_W-DIFF_W){diff_q[DIFF_W-1]}}, diff_q})
                 * $signed({{(PROD_W-DP_W){dp_q[DP_W-1]}}, dp_q});
  assign den_abs = den1_q[EXT_W-1] ? -den1_q : den1_q;

  // Take the dividend magnitude
  assign prod_abs = prod_q[PROD_W-1] ? -prod_q : prod_q;

  // Valid bits of the three stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid1_q <= 1'b0;
      valid2_q <= 1'b0;
      valid3_q <= 1'b0;
    end else if (en_i) begin
      valid1_q <= valid_i;
      valid2_q <= valid1_q;
      valid3_q <= valid2_q;
    end
  end

  // Payload of the three stages
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      diff_q     <= diff_d;
      dp_q       <= dp_d;
      den1_q     <= den_d;
      seg1_q     <= seg_d;
      prod_q     <= prod_d;
      den2_q     <= den_abs[DEN_W-1:0];
      den_neg2_q <= den1_q[EXT_W-1];
      seg2_q     <= seg1_q;
      num3_q     <= prod_abs[NUM_W-1:0];
      den3_q     <= den2_q;
      q_neg3_q   <= prod_q[PROD_W-1] ^ den_neg2_q;
      seg3_q     <= seg2_q;
    end
  end

  assign valid_o = valid3_q;
  assign num_o   = num3_q;
  assign den_o   = den3_q;
  assign q_neg_o = q_neg3_q;
  assign seg_o   = seg3_q;

endmodule

@@ rtl/core/sapm_div.sv @@
// Restoring divider pipeline, one quotient bit per stage.
module sapm_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic [sapm_pkg::NUM_W-1:0]    num_i,
  input  logic [sapm_pkg::DEN_W-1:0]    den_i,
  input  logic                          q_neg_i,
  input  sapm_pkg::seg_t                seg_i,
  output logic                          valid_o,
  output logic [sapm_pkg::NUM_W-1:0]    quo_o,
  output logic                          q_neg_o,
  output sapm_pkg::seg_t                seg_o
);
  import sapm_pkg::*;

  logic             valid_q [DIV_STAGES];
  logic [NUM_W-1:0] shift_q [DIV_STAGES];
  logic [DEN_W-1:0] rem_q   [DIV_STAGES];
  logic [DEN_W-1:0] den_q   [DIV_STAGES];
  logic             q_neg_q [DIV_STAGES];
  seg_t             seg_q   [DIV_STAGES];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    logic             v_in;
    logic [NUM_W-1:0] shift_in;
    logic [DEN_W-1:0] rem_in;
    logic [DEN_W-1:0] den_in;
    logic             q_neg_in;
    seg_t             seg_in;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   trial_sub;
    logic             fit;

    if (k == 0) begin : g_first
      assign v_in     = valid_i;
      assign shift_in = num_i;
      assign rem_in   = '0;
      assign den_in   = den_i;
      assign q_neg_in = q_neg_i;
      assign seg_in   = seg_i;
    end else begin : g_next
      assign v_in     = valid_q[k-1];
      assign shift_in = shift_q[k-1];
      assign rem_in   = rem_q[k-1];
      assign den_in   = den_q[k-1];
      assign q_neg_in = q_neg_q[k-1];
      assign seg_in   = seg_q[k-1];
    end

    // Bring down the next dividend bit and try the subtract
    assign trial     = {rem_in, shift_in[NUM_W-1]};
    assign trial_sub = trial - {1'b0, den_in};
    assign fit       = (trial >= {1'b0, den_in});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (en_i) begin
        valid_q[k] <= v_in;
      end
    end

    // Shift the quotient bit in where the dividend bit left
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]   <= fit ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
        shift_q[k] <= {shift_in[NUM_W-2:0], fit};
        den_q[k]   <= den_in;
        q_neg_q[k] <= q_neg_in;
        seg_q[k]   <= seg_in;
      end
    end
  end

  assign valid_o = valid_q[DIV_STAGES-1];
  assign quo_o   = shift_q[DIV_STAGES-1];
  assign q_neg_o = q_neg_q[DIV_STAGES-1];
  assign seg_o   = seg_q[DIV_STAGES-1];

endmodule

@@ rtl/core/sapm_back.sv @@
// Back stages: apply the quotient sign, add the base, clamp to the segment.
module sapm_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic [sapm_pkg::NUM_W-1:0]    quo_i,
  input  logic                          q_neg_i,
  input  sapm_pkg::seg_t                seg_i,
  output logic                          valid_o,
  output logic [sapm_pkg::PULSE_W-1:0]  pulse_o
);
  import sapm_pkg::*;

  logic signed [SUM_W-1:0]  quo_ext;
  logic signed [SUM_W-1:0]  base_ext;
  logic signed [SUM_W-1:0]  sum_d;
  logic                     valid_a_q;
  logic signed [SUM_W-1:0]  sum_q;
  seg_t                     seg_a_q;

  logic signed [SUM_W-1:0]  lo_ext;
  logic signed [SUM_W-1:0]  hi_ext;
  logic        [PULSE_W-1:0] pulse_d;
  logic                     valid_b_q;
  logic        [PULSE_W-1:0] pulse_q;

  // Signed quotient plus segment base in one adder
  assign quo_ext  = $signed({{(SUM_W-NUM_W){1'b0}}, quo_i});
  assign base_ext = $signed({{(SUM_W-PULSE_W){1'b0}}, seg_i.base});
  assign sum_d    = q_neg_i ? (base_ext - quo_ext) : (base_ext + quo_ext);

  // Clamp low bound first; a zero divisor gives the center pulse
  always_comb begin
    lo_ext = $signed({{(SUM_W-PULSE_W){1'b0}}, seg_a_q.clamp_lo});
    hi_ext = $signed({{(SUM_W-PULSE_W){1'b0}}, seg_a_q.clamp_hi});
    if (seg_a_q.zero_den) begin
      pulse_d = seg_a_q.center;
    end else if (sum_q < lo_ext) begin
      pulse_d = seg_a_q.clamp_lo;
    end else if (sum_q > hi_ext) begin
      pulse_d = seg_a_q.clamp_hi;
    end else begin
      pulse_d = sum_q[PULSE_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
      valid_b_q <= 1'b0;
    end else if (en_i) begin
      valid_a_q <= valid_i;
      valid_b_q <= valid_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sum_q   <= sum_d;
      seg_a_q <= seg_i;
      pulse_q <= pulse_d;
    end
  end

  assign valid_o = valid_b_q;
  assign pulse_o = pulse_q;

endmodule

@@ rtl/core/servo_angle_to_pulse_mapper.sv @@
// Top level of the servo angle to pulse mapper.
//
// Channels: in_i carries a signed angle in tenths of a degree, out_o carries
// the servo compare value, cfg_i writes the six mapping registers by index
// (pulse low, center, high, angle lower, upper, invert); it is always ready.
// Write configuration only while no beat is in flight.
// Pipeline: a taken input beat passes through 38 register stages: three
// front stages (clamp, multiply, magnitude), 32 divider stages at one
// quotient bit each, two back stages and the output register.
// Throughput: one beat per cycle while the skid register is empty; the
// 32-stage divider sets the latency.
// Reset: all valid bits clear and the registers load their defaults
// (1100, 1130, 1230, -50, 100, no invert).
// Stall: the output register has a skid register behind it. When the
// receiver holds ready low, one more beat lands in the skid register, then
// in_i.ready drops and the whole pipe freezes; nothing is lost or repeated.
`include "servo_angle_to_pulse_mapper_defines.svh"

module servo_angle_to_pulse_mapper (
  input  logic           clk_i,
  input  logic           rst_ni,
  sapm_angle_if.sink     in_i,
  sapm_pulse_if.source   out_o,
  sapm_cfg_if.sink       cfg_i
);
  import sapm_pkg::*;

  cfg_t               cfg;
  logic               adv;
  logic               push;

  logic               f_valid;
  logic [NUM_W-1:0]   f_num;
  logic [DEN_W-1:0]   f_den;
  logic               f_q_neg;
  seg_t               f_seg;

  logic               d_valid;
  logic [NUM_W-1:0]   d_quo;
  logic               d_q_neg;
  seg_t               d_seg;

  logic               b_valid;
  logic [PULSE_W-1:0] b_pulse;

  logic               out_valid_q;
  logic               skid_valid_q;
  logic [PULSE_W-1:0] out_data_q;
  logic [PULSE_W-1:0] skid_data_q;

  sapm_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  // Advance the pipe whenever the skid register is free
  assign adv        = !skid_valid_q;
  assign in_i.ready = adv;
  assign push       = b_valid && adv;

  sapm_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (in_i.valid),
    .angle_i (in_i.angle),
    .cfg_i   (cfg),
    .valid_o (f_valid),
    .num_o   (f_num),
    .den_o   (f_den),
    .q_neg_o (f_q_neg),
    .seg_o   (f_seg)
  );

  sapm_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (f_valid),
    .num_i   (f_num),
    .den_i   (f_den),
    .q_neg_i (f_q_neg),
    .seg_i   (f_seg),
    .valid_o (d_valid),
    .quo_o   (d_quo),
    .q_neg_o (d_q_neg),
    .seg_o   (d_seg)
  );

  sapm_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (d_valid),
    .quo_i   (d_quo),
    .q_neg_i (d_q_neg),
    .seg_i   (d_seg),
    .valid_o (b_valid),
    .pulse_o (b_pulse)
  );

  // Output register with skid: refill from skid first, else from the pipe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || out_o.ready) begin
      out_valid_q  <= skid_valid_q || push;
      skid_valid_q <= 1'b0;
    end else if (push) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || out_o.ready) begin
      out_data_q <= skid_valid_q ? skid_data_q : b_pulse;
    end else if (push) begin
      skid_data_q <= b_pulse;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.pulse_width = out_data_q;

  // A frozen pipe always has a beat waiting at the output
  `SAPM_ASSERT_IMPL(a_stall_has_output, clk_i, rst_ni, !in_i.ready, out_o.valid,
    "input stalled with no output beat waiting")
  // The skid register fills only behind a stalled output beat
  `SAPM_ASSERT_IMPL(a_fill_on_stall, clk_i, rst_ni, $fell(in_i.ready),
    $past(out_o.valid && !out_o.ready), "skid filled without an output stall")
  // A taken output beat frees the skid register in the next cycle
  `SAPM_ASSERT_NEXT(a_drain_on_take, clk_i, rst_ni,
    out_o.valid && out_o.ready && !in_i.ready, in_i.ready,
    "skid not drained after an output beat")

endmodule

@@ verif/servo_pulse_compare.sv @@
// Pulse width predictor and in-order compare for the servo pulse mapper testbench.
module servo_pulse_compare (
  input  logic        clk_i,
  input  logic        rst_ni,
  sapm_angle_if       angle_i,
  sapm_pulse_if       pulse_i,
  sapm_cfg_if         cfg_i,
  output int unsigned error_count_o,
  output int unsigned pending_count_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import sapm_pkg::*;

  typedef struct {
    logic [ANGLE_W-1:0] angle;
    logic [PULSE_W-1:0] pulse;
  } pulse_exp_t;

  cfg_t        live_cfg;
  pulse_exp_t  pulse_expected[$];
  int unsigned error_total;

  // Clamp, optionally mirror, then interpolate on the segment the angle falls in
  function automatic logic [PULSE_W-1:0] angle_to_pulse(cfg_t c, logic [ANGLE_W-1:0] angle);
    longint x, lower, upper, lo, ce, hi, r;
    x     = longint'($signed(angle));
    lower = longint'($signed(c.angle_lower));
    upper = longint'($signed(c.angle_upper));
    lo    = longint'(c.pulse_low);
    ce    = longint'(c.pulse_center);
    hi    = longint'(c.pulse_high);
    // The low bound is checked first when the bounds are crossed
    if (x < lower) x = lower;
    else if (x > upper) x = upper;
    if (c.invert_angle) x = -x;
    if (x < 0) begin
      if (lower == 0) begin
        r = ce;
      end else begin
        r = (x - lower) * (ce - lo) / (-lower) + lo;
        if (r < lo) r = lo;
        else if (r > ce) r = ce;
      end
    end else begin
      if (upper == 0) begin
        r = ce;
      end else begin
        r = x * (hi - ce) / upper + ce;
        if (r < ce) r = ce;
        else if (r > hi) r = hi;
      end
    end
    return r[PULSE_W-1:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    pulse_exp_t head;
    if (!rst_ni) begin
      live_cfg = CFG_RESET;
      pulse_expected.delete();
      error_total = 0;
    end else begin
      // Retire the oldest expectation on each output beat
      if (pulse_i.valid && pulse_i.ready) begin
        if (pulse_expected.size() == 0) begin
          error_total++;
          $display("%0t: unexpected pulse_width beat: expected none, actual %0d",
                   $time, pulse_i.pulse_width);
        end else begin
          head = pulse_expected.pop_front();
          if (pulse_i.pulse_width !== head.pulse) begin
            error_total++;
            $display("%0t: pulse_width for angle %0d: expected %0d, actual %0d",
                     $time, $signed(head.angle), head.pulse, pulse_i.pulse_width);
          end
        end
      end
      // Predict each accepted angle beat with the settings in force now
      if (angle_i.valid && angle_i.ready)
        pulse_expected.push_back('{angle: angle_i.angle,
                                   pulse: angle_to_pulse(live_cfg, angle_i.angle)});
      // Track register writes; spare indexes are dropped
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.addr)
          REG_PULSE_LOW:    live_cfg.pulse_low    = cfg_i.data;
          REG_PULSE_CENTER: live_cfg.pulse_center = cfg_i.data;
          REG_PULSE_HIGH:   live_cfg.pulse_high   = cfg_i.data;
          REG_ANGLE_LOWER:  live_cfg.angle_lower  = cfg_i.data;
          REG_ANGLE_UPPER:  live_cfg.angle_upper  = cfg_i.data;
          REG_INVERT_ANGLE: live_cfg.invert_angle = cfg_i.data[0];
          default: ;
        endcase
      end
    end
    error_count_o   <= error_total;
    pending_count_o <= pulse_expected.size();
  end

endmodule

@@ verif/servo_angle_to_pulse_mapper_tb.sv @@
// Top of the servo pulse mapper testbench: clock, reset, stimulus and verdict.
module servo_angle_to_pulse_mapper_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sapm_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_CYCLES = 48;
  localparam int unsigned PHASES       = 13;
  localparam int unsigned PHASE_ITEMS  = 63;

  // Indexes past the last register; writes there must change nothing
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_B = 3'd7;

  logic        clk_i;
  logic        rst_ni;
  int unsigned error_count;
  int unsigned pending_count;
  int unsigned cycle_count;
  int unsigned gap_pct;
  int unsigned stall_pct;
  cfg_t        cur_cfg;

  sapm_angle_if angle_ch();
  sapm_pulse_if pulse_ch();
  sapm_cfg_if   cfg_ch();

  servo_angle_to_pulse_mapper DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (angle_ch),
    .out_o  (pulse_ch),
    .cfg_i  (cfg_ch)
  );

  servo_pulse_compare u_pulse_compare (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .angle_i         (angle_ch),
    .pulse_i         (pulse_ch),
    .cfg_i           (cfg_ch),
    .error_count_o   (error_count),
    .pending_count_o (pending_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Hard stop if the pipe hangs
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  // Receiver: stall in random bursts while stall_pct is nonzero
  initial begin
    pulse_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_pct != 0 && $urandom_range(1, 100) <= stall_pct) begin
        pulse_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
      end
      pulse_ch.ready <= 1'b1;
    end
  end

  // Offer one angle beat, maybe after a gap, and hold until taken
  task automatic send_angle(input logic [ANGLE_W-1:0] angle);
    if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
      angle_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    angle_ch.valid <= 1'b1;
    angle_ch.angle <= angle;
    do @(posedge clk_i); while (!angle_ch.ready);
  endtask

  // Stop sending and wait until every predicted pulse has come out
  task automatic wait_drained();
    angle_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending_count != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic run_angles(input int angles[$]);
    foreach (angles[i]) send_angle(16'(angles[i]));
    wait_drained();
  endtask

  // Write all six registers back to back, led by a write to a spare index
  task automatic write_config(input cfg_t c);
    cfg_reg_e              regs[6];
    logic [CFG_DATA_W-1:0] vals[6];
    regs = '{REG_PULSE_LOW, REG_PULSE_CENTER, REG_PULSE_HIGH,
             REG_ANGLE_LOWER, REG_ANGLE_UPPER, REG_INVERT_ANGLE};
    vals = '{c.pulse_low, c.pulse_center, c.pulse_high, c.angle_lower, c.angle_upper,
             {15'($urandom), c.invert_angle}};
    cfg_ch.valid <= 1'b1;
    cfg_ch.addr  <= $urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B;
    cfg_ch.data  <= 16'($urandom);
    do @(posedge clk_i); while (!cfg_ch.ready);
    for (int i = 0; i < 6; i++) begin
      cfg_ch.addr <= regs[i];
      cfg_ch.data <= vals[i];
      do @(posedge clk_i); while (!cfg_ch.ready);
    end
    cfg_ch.valid <= 1'b0;
    cur_cfg = c;
  endtask

  initial begin : stimulus
    cfg_t        phase_cfg;
    int          lower_i;
    int          upper_i;
    int          angle;
    int          dir_q[$];
    int unsigned kind;
    angle_ch.valid = 1'b0;
    angle_ch.angle = '0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.addr    = '0;
    cfg_ch.data    = '0;
    rst_ni         = 1'b0;
    gap_pct        = 15;
    stall_pct      = 12;
    cur_cfg        = CFG_RESET;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: field extremes, both bounds and just past them
    dir_q = '{-32768, 32767, 0, -1, 1, -50, -51, 100, 101, -25, 37};
    run_angles(dir_q);

    // Full-scale bounds, mirrored: the most negative angle flips to +32768
    write_config('{16'd0, 16'd32768, 16'hFFFF, 16'sh8000, 16'sd32767, 1'b1});
    dir_q = '{-32768, 32767, 0, -1};
    run_angles(dir_q);

    // Zero divisor on the negative side: lower bound at zero, mirrored
    write_config('{16'd1000, 16'd1500, 16'd2000, 16'sd0, 16'sd300, 1'b1});
    dir_q = '{150, -10};
    run_angles(dir_q);

    // Zero divisor on the non-negative side
    write_config('{16'd1000, 16'd1500, 16'd2000, -16'sd300, 16'sd0, 1'b0});
    dir_q = '{-150, 50, 0};
    run_angles(dir_q);

    // Crossed angle bounds and crossed pulse bounds
    write_config('{16'd2000, 16'd1000, 16'd500, 16'sd100, -16'sd100, 1'b0});
    dir_q = '{-200, 0, 200};
    run_angles(dir_q);

    // Random phases: mostly sane servo settings, some raw and some at the extremes
    for (int phase = 0; phase < PHASES; phase++) begin
      kind = (phase == 0 || phase == 7) ? 9 : $urandom_range(0, 9);
      if (kind <= 5) begin
        phase_cfg.pulse_low    = 16'($urandom_range(800, 1200));
        phase_cfg.pulse_center = phase_cfg.pulse_low + 16'($urandom_range(0, 300));
        phase_cfg.pulse_high   = phase_cfg.pulse_center + 16'($urandom_range(0, 300));
        phase_cfg.angle_lower  = 16'(-int'($urandom_range(1, 900)));
        phase_cfg.angle_upper  = 16'($urandom_range(1, 900));
      end else if (kind <= 8) begin
        phase_cfg.pulse_low    = 16'($urandom);
        phase_cfg.pulse_center = 16'($urandom);
        phase_cfg.pulse_high   = 16'($urandom);
        phase_cfg.angle_lower  = 16'($urandom);
        phase_cfg.angle_upper  = 16'($urandom);
      end else begin
        phase_cfg.pulse_low    = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        phase_cfg.pulse_center = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        phase_cfg.pulse_high   = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        phase_cfg.angle_lower  = $urandom_range(0, 1) ? 16'sh8000 : 16'sh8001;
        phase_cfg.angle_upper  = $urandom_range(0, 1) ? 16'sd32767 : 16'sd0;
      end
      phase_cfg.invert_angle = 1'($urandom_range(0, 1));

      // No idling at the tail, and one idle-free stretch every fourth phase
      if (phase >= PHASES - 2 || phase % 4 == 1) begin
        gap_pct   = 0;
        stall_pct = 0;
      end else begin
        gap_pct   = 15;
        stall_pct = 12;
      end

      write_config(phase_cfg);
      lower_i = int'($signed(cur_cfg.angle_lower));
      upper_i = int'($signed(cur_cfg.angle_upper));
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: begin
            if (lower_i <= upper_i)
              angle = lower_i + int'($urandom_range(0, upper_i - lower_i));
            else
              angle = lower_i + int'($urandom_range(0, 6)) - 3;
          end
          4, 5:    angle = ($urandom_range(0, 1) ? lower_i : upper_i)
                           + int'($urandom_range(0, 6)) - 3;
          6:       angle = int'($urandom_range(0, 6)) - 3;
          default: angle = int'($urandom);
        endcase
        send_angle(16'(angle));
      end
      wait_drained();
    end

    if (error_count == 0 && pending_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
